@@ rtl/hwd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the handshake watchdog: state and LED codes, register indexes,
// configuration and item structs. Used by every other file of the block.

package hwd_pkg;

	localparam int unsigned CfgDataW  = 32;
	localparam int unsigned CfgIndexW = 3;
	localparam int unsigned TimeoutW  = 32;
	localparam int unsigned PeriodW   = 16;
	localparam int unsigned ElapsedW  = 16;

	localparam logic [CfgIndexW-1:0] REG_BOOT_TIMEOUT = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_RUN_TIMEOUT  = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_OFF_TIME     = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_BOOT_BLINK   = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_RUN_BLINK    = 3'd4;
	localparam logic [CfgIndexW-1:0] REG_OFF_BLINK    = 3'd5;

	localparam logic [TimeoutW-1:0] BOOT_TIMEOUT_RST = 32'd60000;
	localparam logic [TimeoutW-1:0] RUN_TIMEOUT_RST  = 32'd5000;
	localparam logic [TimeoutW-1:0] OFF_TIME_RST     = 32'd5000;
	localparam logic [PeriodW-1:0]  BOOT_BLINK_RST   = 16'd500;
	localparam logic [PeriodW-1:0]  RUN_BLINK_RST    = 16'd1000;
	localparam logic [PeriodW-1:0]  OFF_BLINK_RST    = 16'd100;

	typedef enum logic [1:0] {
		MODE_BOOT = 2'd0,
		MODE_RUN  = 2'd1,
		MODE_OFF  = 2'd2
	} wd_mode_t;

	typedef enum logic [1:0] {
		LED_DARK  = 2'd0,
		LED_ON    = 2'd1,
		LED_BLINK = 2'd2
	} led_t;

	typedef struct packed {
		logic [TimeoutW-1:0] boot_timeout_ms;
		logic [TimeoutW-1:0] run_timeout_ms;
		logic [TimeoutW-1:0] off_time_ms;
		logic [PeriodW-1:0]  boot_blink_ms;
		logic [PeriodW-1:0]  run_blink_ms;
		logic [PeriodW-1:0]  off_blink_ms;
	} cfg_t;

	typedef struct packed {
		logic                wd_enable;
		logic                host_level;
		logic [ElapsedW-1:0] elapsed_ms;
	} tick_t;

	typedef struct packed {
		logic               power_enable;
		logic               master_level;
		led_t               led_mode;
		logic [PeriodW-1:0] blink_period_ms;
		wd_mode_t           wd_state;
	} result_t;

endpackage

@@ rtl/hwd_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for tick items and result items.
// Depends on hwd_pkg for the field widths.

interface hwd_tick_if;
	import hwd_pkg::*;
	logic                valid;
	logic                ready;
	logic                wd_enable;
	logic                host_level;
	logic [ElapsedW-1:0] elapsed_ms;

	modport source (output valid, wd_enable, host_level, elapsed_ms, input ready);
	modport sink (input valid, wd_enable, host_level, elapsed_ms, output ready);
endinterface

interface hwd_status_if;
	import hwd_pkg::*;
	logic               valid;
	logic               ready;
	logic               power_enable;
	logic               master_level;
	logic [1:0]         led_mode;
	logic [PeriodW-1:0] blink_period_ms;
	logic [1:0]         wd_state;

	modport source (output valid, power_enable, master_level, led_mode,
		blink_period_ms, wd_state, input ready);
	modport sink (input valid, power_enable, master_level, led_mode,
		blink_period_ms, wd_state, output ready);
endinterface

@@ rtl/hwd_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file of the watchdog, written through a plain write port.
// Depends on hwd_pkg.

module hwd_cfg_regs
	import hwd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boot_timeout_ms <= BOOT_TIMEOUT_RST;
			cfg_q.run_timeout_ms  <= RUN_TIMEOUT_RST;
			cfg_q.off_time_ms     <= OFF_TIME_RST;
			cfg_q.boot_blink_ms   <= BOOT_BLINK_RST;
			cfg_q.run_blink_ms    <= RUN_BLINK_RST;
			cfg_q.off_blink_ms    <= OFF_BLINK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOOT_TIMEOUT: cfg_q.boot_timeout_ms <= cfg_wdata[TimeoutW-1:0];
				REG_RUN_TIMEOUT:  cfg_q.run_timeout_ms  <= cfg_wdata[TimeoutW-1:0];
				REG_OFF_TIME:     cfg_q.off_time_ms     <= cfg_wdata[TimeoutW-1:0];
				REG_BOOT_BLINK:   cfg_q.boot_blink_ms   <= cfg_wdata[PeriodW-1:0];
				REG_RUN_BLINK:    cfg_q.run_blink_ms    <= cfg_wdata[PeriodW-1:0];
				REG_OFF_BLINK:    cfg_q.off_blink_ms    <= cfg_wdata[PeriodW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/hwd_core.sv @@
`timescale 1ns / 1ps
// Watchdog state machine: timer, mode, master and power registers and the
// next-state logic applied to one registered tick item. Depends on hwd_pkg.

module hwd_core
	import hwd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  tick_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	wd_mode_t            mode_q, mode_n;
	logic [TimeoutW-1:0] timer_q, timer_n, timer_sat;
	logic [TimeoutW:0]   timer_sum;
	logic                master_q, master_n;
	logic                power_q, power_n;
	led_t                led;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_BOOT;
			timer_q  <= '0;
			master_q <= 1'b1;
			power_q  <= 1'b1;
		end else if (step) begin
			mode_q   <= mode_n;
			timer_q  <= timer_n;
			master_q <= master_n;
			power_q  <= power_n;
		end
	end

	assign timer_sum = {1'b0, timer_q} + {{(TimeoutW + 1 - ElapsedW){1'b0}}, item.elapsed_ms};
	assign timer_sat = timer_sum[TimeoutW] ? '1 : timer_sum[TimeoutW-1:0];

	always_comb begin
		mode_n   = mode_q;
		timer_n  = '0;
		master_n = master_q;
		power_n  = power_q;
		led      = LED_DARK;
		if (item.wd_enable) begin
			timer_n = timer_sat;
			unique case (mode_q)
				MODE_BOOT: begin
					if (timer_sat < cfg.boot_timeout_ms) begin
						if (item.host_level) begin
							mode_n  = MODE_RUN;
							timer_n = '0;
						end
					end else begin
						mode_n   = MODE_OFF;
						timer_n  = '0;
						master_n = 1'b1;
						power_n  = 1'b0;
					end
				end
				MODE_RUN: begin
					if (timer_sat < cfg.run_timeout_ms) begin
						if (master_q == item.host_level) begin
							master_n = ~item.host_level;
							timer_n  = '0;
						end
					end else begin
						mode_n   = MODE_OFF;
						timer_n  = '0;
						master_n = 1'b1;
						power_n  = 1'b0;
					end
				end
				MODE_OFF: begin
					if (timer_sat >= cfg.off_time_ms) begin
						mode_n  = MODE_BOOT;
						timer_n = '0;
						power_n = 1'b1;
					end
				end
				default: begin
					mode_n   = MODE_OFF;
					timer_n  = '0;
					master_n = 1'b1;
					power_n  = 1'b0;
				end
			endcase
			led = (mode_n == MODE_OFF) ? LED_ON : LED_BLINK;
		end
	end

	always_comb begin
		result.power_enable = power_n;
		result.master_level = master_n;
		result.led_mode     = led;
		result.wd_state     = mode_n;
		unique case (mode_n)
			MODE_BOOT: result.blink_period_ms = cfg.boot_blink_ms;
			MODE_RUN:  result.blink_period_ms = cfg.run_blink_ms;
			default:   result.blink_period_ms = cfg.off_blink_ms;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_power_cut_only_off: assert property (@(posedge clk) disable iff (!arst_n)
		(power_q == 1'b0) == (mode_q == MODE_OFF))
		else $error("power line and power-off state disagree");

	a_disabled_clears_timer: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.wd_enable |=> timer_q == '0)
		else $error("timer not cleared by a disabled tick");

	a_timeout_cuts_power: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.wd_enable && mode_q == MODE_RUN && timer_sat >= cfg.run_timeout_ms
		|=> mode_q == MODE_OFF && master_q && timer_q == '0)
		else $error("run timeout did not enter power off");
`endif

endmodule

@@ rtl/handshake_watchdog_fsm.sv @@
`timescale 1ns / 1ps
// Handshake watchdog top level: input register, state machine step, result register.
// An accepted tick item's result is registered after its state machine step; one item per cycle
// while status.ready holds; the state update between the two registers is combinational.
// Reset (arst_n low) empties both registers, restores the register defaults and
// puts the watchdog in booting with host power on. Depends on hwd_pkg and hwd_if.

module handshake_watchdog_fsm
	import hwd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	hwd_tick_if.sink             tick,
	hwd_status_if.source         status,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_wdata
);

	cfg_t    cfg;
	tick_t   tick_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    adv;

	hwd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hwd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (tick_s1),
		.cfg    (cfg),
		.result (res_comb)
	);

	assign adv        = valid_s1 && (!valid_s2 || status.ready);
	assign tick.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (tick.ready) begin
				valid_s1 <= tick.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (status.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1.wd_enable  <= tick.wd_enable;
			tick_s1.host_level <= tick.host_level;
			tick_s1.elapsed_ms <= tick.elapsed_ms;
		end
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	assign status.valid           = valid_s2;
	assign status.power_enable    = res_s2.power_enable;
	assign status.master_level    = res_s2.master_level;
	assign status.led_mode        = res_s2.led_mode;
	assign status.blink_period_ms = res_s2.blink_period_ms;
	assign status.wd_state        = res_s2.wd_state;

`ifndef NO_ASSERTIONS
	a_adv_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("result register empty after a step");

	a_no_overwrite_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && tick.ready |-> adv)
		else $error("input register overwritten before its step");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !status.ready |=> valid_s2 && !$past(adv))
		else $error("stalled result replaced");
`endif

endmodule

@@ tb/handshake_watchdog_fsm_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for handshake_watchdog_fsm: drives tick items, predicts every
// status item in a small scoreboard class and compares them as they leave the block.
// Depends on hwd_pkg, hwd_if and the block itself.

module handshake_watchdog_fsm_test;
	import hwd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned PHASE_COUNT = 8;
	localparam int unsigned PHASE_TICKS = 244;
	localparam int unsigned EPISODE_TICKS = 20;
	localparam logic [CfgIndexW-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CfgIndexW-1:0] REG_SPARE_HI = 3'd7;

	class watchdog_tracker;
		cfg_t      regs;
		wd_mode_t  mode;
		logic [31:0] timer;
		logic      master;
		logic      power;
		result_t   pending[$];
		int        errors;
		int        checked;
		int        cuts;

		function new();
			regs.boot_timeout_ms = BOOT_TIMEOUT_RST;
			regs.run_timeout_ms  = RUN_TIMEOUT_RST;
			regs.off_time_ms     = OFF_TIME_RST;
			regs.boot_blink_ms   = BOOT_BLINK_RST;
			regs.run_blink_ms    = RUN_BLINK_RST;
			regs.off_blink_ms    = OFF_BLINK_RST;
			mode    = MODE_BOOT;
			timer   = '0;
			master  = 1'b1;
			power   = 1'b1;
			errors  = 0;
			checked = 0;
			cuts    = 0;
		endfunction

		function void set_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
				REG_BOOT_TIMEOUT: regs.boot_timeout_ms = data;
				REG_RUN_TIMEOUT:  regs.run_timeout_ms  = data;
				REG_OFF_TIME:     regs.off_time_ms     = data;
				REG_BOOT_BLINK:   regs.boot_blink_ms   = data[PeriodW-1:0];
				REG_RUN_BLINK:    regs.run_blink_ms    = data[PeriodW-1:0];
				REG_OFF_BLINK:    regs.off_blink_ms    = data[PeriodW-1:0];
				default: ;
			endcase
		endfunction

		function void power_cut();
			power  = 1'b0;
			master = 1'b1;
			mode   = MODE_OFF;
			timer  = '0;
			cuts++;
		endfunction

		function void note_tick(tick_t t);
			result_t     want;
			logic [32:0] sum;
			if (t.wd_enable) begin
				sum = {1'b0, timer} + {17'd0, t.elapsed_ms};
				timer = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				case (mode)
					MODE_BOOT: begin
						if (timer < regs.boot_timeout_ms) begin
							if (t.host_level) begin
								mode  = MODE_RUN;
								timer = '0;
							end
						end else begin
							power_cut();
						end
					end
					MODE_RUN: begin
						if (timer < regs.run_timeout_ms) begin
							if (master == t.host_level) begin
								master = ~t.host_level;
								timer  = '0;
							end
						end else begin
							power_cut();
						end
					end
					MODE_OFF: begin
						if (timer >= regs.off_time_ms) begin
							mode  = MODE_BOOT;
							timer = '0;
							power = 1'b1;
						end
					end
					default: power_cut();
				endcase
				want.led_mode = (mode == MODE_OFF) ? LED_ON : LED_BLINK;
			end else begin
				timer = '0;
				want.led_mode = LED_DARK;
			end
			want.power_enable = power;
			want.master_level = master;
			want.wd_state     = mode;
			case (mode)
				MODE_BOOT: want.blink_period_ms = regs.boot_blink_ms;
				MODE_RUN:  want.blink_period_ms = regs.run_blink_ms;
				default:   want.blink_period_ms = regs.off_blink_ms;
			endcase
			pending.push_back(want);
		endfunction

		function void check_status(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected status item: pwr=%0d mst=%0d led=%0d per=%0d st=%0d",
						got.power_enable, got.master_level, got.led_mode,
						got.blink_period_ms, got.wd_state);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.power_enable !== want.power_enable || got.master_level !== want.master_level
					|| got.led_mode !== want.led_mode
					|| got.blink_period_ms !== want.blink_period_ms
					|| got.wd_state !== want.wd_state) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch at item %0d: expected pwr=%0d mst=%0d led=%0d per=%0d st=%0d",
						checked, want.power_enable, want.master_level, want.led_mode,
						want.blink_period_ms, want.wd_state);
					$display("    actual pwr=%0d mst=%0d led=%0d per=%0d st=%0d",
						got.power_enable, got.master_level, got.led_mode,
						got.blink_period_ms, got.wd_state);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic                 cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0]  cfg_wdata;

	hwd_tick_if   tick_ch();
	hwd_status_if status_ch();

	watchdog_tracker sb;
	int unsigned cycles;
	int tick_gap_pct;
	int stall_pct;
	int settings_used;

	handshake_watchdog_fsm dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.status    (status_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		status_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			status_ch.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin : watch
		tick_t   seen;
		result_t got;
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready) begin
				seen.wd_enable  = tick_ch.wd_enable;
				seen.host_level = tick_ch.host_level;
				seen.elapsed_ms = tick_ch.elapsed_ms;
				sb.note_tick(seen);
			end
			if (status_ch.valid && status_ch.ready) begin
				got.power_enable    = status_ch.power_enable;
				got.master_level    = status_ch.master_level;
				got.led_mode        = led_t'(status_ch.led_mode);
				got.blink_period_ms = status_ch.blink_period_ms;
				got.wd_state        = wd_mode_t'(status_ch.wd_state);
				sb.check_status(got);
			end
		end
	end

	task automatic send_tick(input logic en, input logic host, input logic [ElapsedW-1:0] el);
		while ($urandom_range(99) < tick_gap_pct) begin
			tick_ch.valid      = 1'b0;
			tick_ch.wd_enable  = 1'($urandom_range(1));
			tick_ch.host_level = 1'($urandom_range(1));
			tick_ch.elapsed_ms = ElapsedW'($urandom_range(65535));
			@(negedge clk);
		end
		tick_ch.valid      = 1'b1;
		tick_ch.wd_enable  = en;
		tick_ch.host_level = host;
		tick_ch.elapsed_ms = el;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic drain();
		tick_ch.valid = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [CfgDataW-1:0] pick_timeout();
		case ($urandom_range(3))
			0: return $urandom_range(3000);
			1: return $urandom_range(200000);
			2: return $urandom;
			default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
		endcase
	endfunction

	task automatic apply_setting(input int phase);
		case (phase)
			0: begin
				write_reg(REG_BOOT_TIMEOUT, BOOT_TIMEOUT_RST);
				write_reg(REG_RUN_TIMEOUT, RUN_TIMEOUT_RST);
				write_reg(REG_OFF_TIME, OFF_TIME_RST);
				write_reg(REG_BOOT_BLINK, {16'd0, BOOT_BLINK_RST});
				write_reg(REG_RUN_BLINK, {16'd0, RUN_BLINK_RST});
				write_reg(REG_OFF_BLINK, {16'd0, OFF_BLINK_RST});
			end
			1: begin
				write_reg(REG_BOOT_TIMEOUT, '0);
				write_reg(REG_RUN_TIMEOUT, '0);
				write_reg(REG_OFF_TIME, '0);
				write_reg(REG_BOOT_BLINK, '0);
				write_reg(REG_RUN_BLINK, '0);
				write_reg(REG_OFF_BLINK, '0);
				write_reg(REG_SPARE_LO, $urandom);
				write_reg(REG_SPARE_HI, $urandom);
			end
			2: begin
				write_reg(REG_BOOT_TIMEOUT, '1);
				write_reg(REG_RUN_TIMEOUT, '1);
				write_reg(REG_OFF_TIME, '1);
				write_reg(REG_BOOT_BLINK, '1);
				write_reg(REG_RUN_BLINK, '1);
				write_reg(REG_OFF_BLINK, '1);
			end
			default: begin
				write_reg(REG_BOOT_TIMEOUT, pick_timeout());
				write_reg(REG_RUN_TIMEOUT, pick_timeout());
				write_reg(REG_OFF_TIME, pick_timeout());
				write_reg(REG_BOOT_BLINK, $urandom);
				write_reg(REG_RUN_BLINK, $urandom);
				write_reg(REG_OFF_BLINK, $urandom);
				if ($urandom_range(1))
					write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
			end
		endcase
		settings_used++;
	endtask

	task automatic random_tick(input int echo_pct, input int elapsed_cap);
		logic                en;
		logic                host;
		logic [ElapsedW-1:0] el;
		int                  pick;
		en = ($urandom_range(99) < 92);
		host = ($urandom_range(99) < echo_pct) ? sb.master : ~sb.master;
		pick = $urandom_range(99);
		if (pick < 5)
			el = '0;
		else if (pick < 10)
			el = '1;
		else if (pick < 40)
			el = ElapsedW'($urandom_range(65535));
		else
			el = ElapsedW'($urandom_range(elapsed_cap));
		send_tick(en, host, el);
	endtask

	initial begin
		int echo_pct;
		int elapsed_cap;
		int echo_choices[4];
		int cap_choices[3];
		echo_choices = '{10, 50, 80, 95};
		cap_choices  = '{100, 2000, 65535};
		sb = new();
		cycles = 0;
		settings_used = 1;
		tick_gap_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.wd_enable = 1'b0;
		tick_ch.host_level = 1'b0;
		tick_ch.elapsed_ms = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the state machine through each transition with the reset registers.
		send_tick(1'b0, 1'b1, 16'hFFFF);
		send_tick(1'b1, 1'b0, 16'd0);
		send_tick(1'b1, 1'b1, 16'd100);
		send_tick(1'b1, 1'b1, 16'd10);
		send_tick(1'b1, 1'b0, 16'd4999);
		send_tick(1'b1, 1'b0, 16'd4999);
		send_tick(1'b1, 1'b0, 16'd1);
		send_tick(1'b1, 1'b0, 16'd4999);
		send_tick(1'b0, 1'b0, 16'd1000);
		send_tick(1'b1, 1'b1, 16'd4999);
		send_tick(1'b1, 1'b1, 16'd1);
		send_tick(1'b1, 1'b0, 16'hFFFF);
		send_tick(1'b1, 1'b0, 16'hFFFF);
		send_tick(1'b1, 1'b1, 16'd59999);
		send_tick(1'b1, 1'b0, 16'hFFFF);
		send_tick(1'b1, 1'b0, 16'd5000);
		send_tick(1'b1, 1'b1, 16'd60000);
		send_tick(1'b1, 1'b1, 16'd5000);
		send_tick(1'b1, 1'b1, 16'd0);
		send_tick(1'b0, 1'b1, 16'd0);
		send_tick(1'b1, 1'b1, 16'd0);
		send_tick(1'b1, 1'b1, 16'd4999);
		send_tick(1'b1, 1'b1, 16'd0);
		send_tick(1'b1, 1'b0, 16'd0);
		drain();

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			apply_setting(phase);
			case (phase % 4)
				0: begin tick_gap_pct = 0;  stall_pct = 0;  end
				1: begin tick_gap_pct = 57; stall_pct = 0;  end
				2: begin tick_gap_pct = 0;  stall_pct = 57; end
				default: begin tick_gap_pct = 15; stall_pct = 15; end
			endcase
			echo_pct = 50;
			elapsed_cap = 2000;
			for (int n = 0; n < PHASE_TICKS; n++) begin
				if (n % EPISODE_TICKS == 0) begin
					echo_pct    = echo_choices[$urandom_range(3)];
					elapsed_cap = cap_choices[$urandom_range(2)];
				end
				random_tick(echo_pct, elapsed_cap);
			end
			drain();
		end

		sb.errors += sb.pending.size();
		$display("Checked %0d status items over %0d register settings and four idle patterns.",
			sb.checked, settings_used);
		$display("The run saw %0d predicted power cuts; %0d errors.", sb.cuts, sb.errors);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
